### design/bsmt_pkg.sv
// ----------------------------------------------------------------------------
// bsmt_pkg: shared types and sizes for the buy/sell match table
// Request and result layouts, and default sizes handed to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package bsmt_pkg;

    localparam int BSMT_TABLE_DEPTH = 128;
    localparam int CATEGORY_BITS    = 8;
    localparam int PRICE_BITS       = 16;
    localparam int HELD_BITS        = 8;

    // One offer, as received and as held in the table
    typedef struct packed {
        logic [CATEGORY_BITS-1:0] category_id;
        logic                     for_sale;
        logic [PRICE_BITS-1:0]    price;
    } t_offer;

    // One result per offer
    typedef struct packed {
        logic                     matched;
        logic [CATEGORY_BITS-1:0] sale_category;
        logic [PRICE_BITS-1:0]    sale_price;
        logic                     stored;
        logic                     dropped;
        logic [HELD_BITS-1:0]     entries_held;
    } t_result;

endpackage

`default_nettype wire

### design/buy_sell_match_table.sv
// ----------------------------------------------------------------------------
// buy_sell_match_table: pairs buy and sell offers kept in arrival order
// Scans a single-port-read table for the oldest opposite offer, removes it
// and closes the gap; else appends the new offer if room, or drops it.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                         payload
//  offer     in         i_offer_valid / o_offer_ready     i_offer  (t_offer)
//  result    out        o_result_valid / i_result_ready   o_result (t_result)
//
//  An offer is taken while idle, then scanned (one table entry read per
//  cycle until the first pair or the end of the held entries; no scan
//  when the table is empty); after a pair the gap is closed (one entry
//  moved per cycle). Both rates are set by the one-read memory port.
//  Reset (synchronous, active low) empties the table at once: no clear pass.
//  The result sits in an output register; a stalled result holds the block
//  in its final step, and a new offer is taken once the block is back idle.
// ----------------------------------------------------------------------------
`default_nettype none

module buy_sell_match_table
    import bsmt_pkg::*;
#(
    parameter int TABLE_DEPTH = BSMT_TABLE_DEPTH
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_offer_valid,
    output logic         o_offer_ready,
    input  wire t_offer  i_offer,
    output logic         o_result_valid,
    input  wire logic    i_result_ready,
    output t_result      o_result
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE  = CW'(1);
    localparam logic [CW-1:0] TWO  = CW'(2);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RESULT
    } t_state;

    // Table memory: one write port, one registered read port
    t_offer          mem [TABLE_DEPTH];
    t_offer          r_rdata;
    logic [AW-1:0]   w_raddr;
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    t_offer          w_wdata;

    t_state          r_state, n_state;
    t_offer          r_offer, n_offer;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_match, n_match;
    logic [CATEGORY_BITS-1:0] r_scat, n_scat;
    logic [PRICE_BITS-1:0]    r_sprice, n_sprice;
    logic            r_out_valid, n_out_valid;
    t_result         r_result, n_result;

    logic            w_pair;
    logic            w_load;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[w_raddr];
    end

    // Pair test of the held entry against the current offer
    always_comb begin
        w_pair = (r_rdata.category_id == r_offer.category_id) &&
                 (r_rdata.for_sale != r_offer.for_sale);
        if (r_rdata.for_sale) begin
            w_pair = w_pair && (r_rdata.price <= r_offer.price);
        end else begin
            w_pair = w_pair && (r_offer.price <= r_rdata.price);
        end
    end

    assign w_load = (r_state == S_RESULT) && (!r_out_valid || i_result_ready);

    // Next state and datapath
    always_comb begin
        n_state     = r_state;
        n_offer     = r_offer;
        n_count     = r_count;
        n_idx       = r_idx;
        n_match     = r_match;
        n_scat      = r_scat;
        n_sprice    = r_sprice;
        n_out_valid = r_out_valid;
        n_result    = r_result;
        w_raddr     = r_idx[AW-1:0];
        w_we        = 1'b0;
        w_waddr     = r_idx[AW-1:0];
        w_wdata     = r_rdata;

        if (r_out_valid && i_result_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                // Take a request and start reading from the oldest entry
                w_raddr = '0;
                if (i_offer_valid) begin
                    n_offer  = i_offer;
                    n_idx    = '0;
                    n_match  = 1'b0;
                    n_scat   = '0;
                    n_sprice = '0;
                    n_state  = (r_count == '0) ? S_RESULT : S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_pair) begin
                    // Record the seller side and start closing the gap
                    n_match  = 1'b1;
                    n_scat   = r_offer.for_sale ? r_offer.category_id
                                                : r_rdata.category_id;
                    n_sprice = r_offer.for_sale ? r_offer.price : r_rdata.price;
                    w_raddr  = AW'(r_idx + ONE);
                    n_state  = ((r_idx + ONE) < r_count) ? S_SHIFT : S_RESULT;
                end else if ((r_idx + ONE) < r_count) begin
                    w_raddr = AW'(r_idx + ONE);
                    n_idx   = r_idx + ONE;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_SHIFT: begin
                // Move the next entry up one place
                w_we    = 1'b1;
                w_waddr = r_idx[AW-1:0];
                w_wdata = r_rdata;
                n_idx   = r_idx + ONE;
                if ((r_idx + TWO) < r_count) begin
                    w_raddr = AW'(r_idx + TWO);
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                // Update the fill count, append if room, and post the result
                if (w_load) begin
                    n_result.matched       = r_match;
                    n_result.sale_category = r_scat;
                    n_result.sale_price    = r_sprice;
                    n_result.stored        = 1'b0;
                    n_result.dropped       = 1'b0;
                    if (r_match) begin
                        n_count = r_count - ONE;
                    end else if (r_count < FULL) begin
                        w_we            = 1'b1;
                        w_waddr         = r_count[AW-1:0];
                        w_wdata         = r_offer;
                        n_count         = r_count + ONE;
                        n_result.stored = 1'b1;
                    end else begin
                        n_result.dropped = 1'b1;
                    end
                    n_result.entries_held = HELD_BITS'(n_count);
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_offer  <= n_offer;
        r_idx    <= n_idx;
        r_match  <= n_match;
        r_scat   <= n_scat;
        r_sprice <= n_sprice;
        r_result <= n_result;
    end

    assign o_offer_ready  = (r_state == S_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_result       = r_result;

    // Fill count never passes the table size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("entry count above table depth");

    // A move always reads an entry that is held
    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> ((r_idx + ONE) < r_count))
        else $error("gap close beyond held entries");

    // A pair removes exactly one entry
    a_match_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_match) |=> (r_count == $past(r_count) - ONE))
        else $error("pair did not remove one entry");

    // A dropped offer is only reported while the table is full
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.dropped) |-> (r_count == FULL))
        else $error("drop reported with room left");

    // Outcomes exclude each other
    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |->
            $onehot({o_result.matched, o_result.stored, o_result.dropped}))
        else $error("result outcome not unique");

endmodule

`default_nettype wire
